// ===== design/siph_pkg.sv =====
// ----------------------------------------------------------------------------
// siph_pkg: shared types, constants and round functions for the keyed hash
// Lane record, init constants, tweak bytes, register indexes and the
// SipRound and compression functions used by the absorb and final paths.
// ----------------------------------------------------------------------------
`default_nettype none

package siph_pkg;

   // widths of the item and result fields
   localparam int unsigned WordWidth      = 64;
   localparam int unsigned CountWidth     = 4;
   localparam int unsigned PartWidth      = 56;
   localparam int unsigned LenWidth       = 8;
   localparam int unsigned CsrIndexWidth  = 2;
   localparam int unsigned BytesPerWord   = 8;

   // configuration register indexes
   localparam logic [CsrIndexWidth-1:0] CsrKeyLow    = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CsrKeyHigh   = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CsrWideDigest = 2'd2;

   // lane init constants
   localparam logic [WordWidth-1:0] InitA = 64'h736f6d6570736575;
   localparam logic [WordWidth-1:0] InitB = 64'h646f72616e646f6d;
   localparam logic [WordWidth-1:0] InitC = 64'h6c7967656e657261;
   localparam logic [WordWidth-1:0] InitD = 64'h7465646279746573;

   // finalization tweaks
   localparam logic [WordWidth-1:0] FinalNarrow = 64'h0000_0000_0000_00ff;
   localparam logic [WordWidth-1:0] FinalWide   = 64'h0000_0000_0000_00ee;
   localparam logic [WordWidth-1:0] SecondHalf  = 64'h0000_0000_0000_00dd;

   // full count of one item
   localparam logic [CountWidth-1:0] FullCount = 4'd8;

   // number of registered stages in the finalization pipe, output included
   localparam int unsigned FinalStages  = 6;
   localparam int unsigned StepIdxWidth = 3;

   typedef struct packed {
      logic [WordWidth-1:0] a;
      logic [WordWidth-1:0] b;
      logic [WordWidth-1:0] c;
      logic [WordWidth-1:0] d;
   } lanes_type;

   // work handed from the absorb logic to the finalization pipe
   typedef struct packed {
      lanes_type            lanes;
      logic [WordWidth-1:0] m;
      logic                 wide;
   } final_job_type;

   function automatic logic [WordWidth-1:0] rotl(input logic [WordWidth-1:0] x,
                                                  input logic [5:0] r);
      logic [6:0] rr;
      rr = 7'd64 - {1'b0, r};
      return (x << r) | (x >> rr);
   endfunction

   // one SipRound
   function automatic lanes_type sip_round(input lanes_type s);
      lanes_type t;
      t.a = s.a + s.b;
      t.b = rotl(s.b, 6'd13) ^ t.a;
      t.a = rotl(t.a, 6'd32);
      t.c = s.c + s.d;
      t.d = rotl(s.d, 6'd16) ^ t.c;
      t.a = t.a + t.d;
      t.d = rotl(t.d, 6'd21) ^ t.a;
      t.c = t.c + t.b;
      t.b = rotl(t.b, 6'd17) ^ t.c;
      t.c = rotl(t.c, 6'd32);
      return t;
   endfunction

   function automatic lanes_type double_round(input lanes_type s);
      return sip_round(sip_round(s));
   endfunction

   // absorb one 8-byte block with two rounds
   function automatic lanes_type compress(input lanes_type s,
                                          input logic [WordWidth-1:0] m);
      lanes_type t;
      t   = s;
      t.d = t.d ^ m;
      t   = double_round(t);
      t.a = t.a ^ m;
      return t;
   endfunction

   // lanes at the start of a message
   function automatic lanes_type start_lanes(input logic [WordWidth-1:0] k0,
                                             input logic [WordWidth-1:0] k1,
                                             input logic wide);
      lanes_type t;
      t.a = k0 ^ InitA;
      t.b = k1 ^ InitB ^ (wide ? FinalWide : '0);
      t.c = k0 ^ InitC;
      t.d = k1 ^ InitD;
      return t;
   endfunction

endpackage

`default_nettype wire

// ===== design/siph_if.sv =====
// ----------------------------------------------------------------------------
// siph_if: channel interfaces of the keyed hash
// Message item channel, digest channel and register write channel, each
// with valid/ready and a source and a sink modport.
// ----------------------------------------------------------------------------
`default_nettype none

// message item channel
interface siph_req_if import siph_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [WordWidth-1:0]  data_bytes;
   logic [CountWidth-1:0] byte_count;
   logic                  last;

   modport source (output valid, output data_bytes, output byte_count, output last,
                   input ready);
   modport sink   (input valid, input data_bytes, input byte_count, input last,
                   output ready);
endinterface

// digest channel
interface siph_rsp_if import siph_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [WordWidth-1:0] digest_low;
   logic [WordWidth-1:0] digest_high;

   modport source (output valid, output digest_low, output digest_high, input ready);
   modport sink   (input valid, input digest_low, input digest_high, output ready);
endinterface

// register write channel
interface siph_csr_if import siph_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [CsrIndexWidth-1:0] index;
   logic [WordWidth-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/siph_final.sv =====
// ----------------------------------------------------------------------------
// siph_final: finalization pipe of the keyed hash
// Final block compression, four finalization rounds and four more for the
// second half (kept in wide mode), two rounds per stage, ending in the output
// register. Each stage holds its item until the next one has room.
// ----------------------------------------------------------------------------
`default_nettype none

module siph_final import siph_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          fin_valid,
   output logic               fin_ready,
   input  wire final_job_type fin_job,
   siph_rsp_if.source         rsp
);

   localparam int unsigned LastStage = FinalStages - 1;

   // step codes of the stage transforms
   localparam logic [StepIdxWidth-1:0] StepCompress   = 3'd0;
   localparam logic [StepIdxWidth-1:0] StepFirstHalf  = 3'd2;
   localparam logic [StepIdxWidth-1:0] StepSecondHalf = 3'd4;

   typedef struct packed {
      lanes_type            lanes;
      logic [WordWidth-1:0] m;
      logic                 wide;
      logic [WordWidth-1:0] r0;
      logic [WordWidth-1:0] r1;
   } stage_type;

   stage_type              st_ff [FinalStages];
   stage_type              nxt   [FinalStages-1];
   logic [FinalStages-1:0] valid_ff;
   logic [FinalStages-1:0] slot_free;

   // work done between stage idx and stage idx + 1
   function automatic stage_type stage_step(input logic [StepIdxWidth-1:0] idx,
                                            input stage_type s);
      stage_type t;
      lanes_type l;
      t = s;
      l = s.lanes;
      case (idx)
         StepCompress: begin
            l   = compress(l, s.m);
            l.c = l.c ^ (s.wide ? FinalWide : FinalNarrow);
         end
         StepFirstHalf: begin
            l    = double_round(l);
            t.r0 = l.a ^ l.b ^ l.c ^ l.d;
            l.b  = l.b ^ SecondHalf;
         end
         StepSecondHalf: begin
            l    = double_round(l);
            t.r1 = s.wide ? (l.a ^ l.b ^ l.c ^ l.d) : '0;
         end
         default: begin
            l = double_round(l);
         end
      endcase
      t.lanes = l;
      return t;
   endfunction

   // stage transforms
   always_comb begin
      for (int k = 0; k < FinalStages - 1; k++) begin
         nxt[k] = stage_step(StepIdxWidth'(k), st_ff[k]);
      end
   end

   // a stage takes new work when it is empty or its item moves on
   always_comb begin
      slot_free[LastStage] = !valid_ff[LastStage] || rsp.ready;
      for (int k = FinalStages - 2; k >= 0; k--) begin
         slot_free[k] = !valid_ff[k] || slot_free[k+1];
      end
   end

   assign fin_ready = slot_free[0];

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (slot_free[0]) begin
            valid_ff[0] <= fin_valid;
         end
         for (int k = 1; k < FinalStages; k++) begin
            if (slot_free[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (slot_free[0]) begin
         st_ff[0].lanes <= fin_job.lanes;
         st_ff[0].m     <= fin_job.m;
         st_ff[0].wide  <= fin_job.wide;
         st_ff[0].r0    <= '0;
         st_ff[0].r1    <= '0;
      end
      for (int k = 1; k < FinalStages; k++) begin
         if (slot_free[k]) begin
            st_ff[k] <= nxt[k-1];
         end
      end
   end

   // result transfer
   assign rsp.valid       = valid_ff[LastStage];
   assign rsp.digest_low  = st_ff[LastStage].r0;
   assign rsp.digest_high = st_ff[LastStage].r1;

endmodule

`default_nettype wire

// ===== design/siphash_keyed_stream_hash.sv =====
// ----------------------------------------------------------------------------
// siphash_keyed_stream_hash: keyed SipHash-2-4 over a byte stream
// Absorbs up to eight message bytes per item and returns a 64-bit or
// 128-bit digest when an item marked last has been taken.
// ----------------------------------------------------------------------------
// The block takes one message item per clock cycle while the finalization
// pipe has room. Each item brings zero to eight little-endian bytes; a count
// above eight counts as eight. The lane registers loop through two SipRounds
// of combinational logic, and that feedback path sets the clock. An item
// marked last hands the lanes and the padded final block to a six-stage
// finalization pipe (two rounds per stage) that offers its digest from the
// output register, and the lanes restart for the next message as the item
// is taken. The pipe drains on its own; a stalled digest backs up the pipe,
// and items are refused only once the first pipe stage is full. Register
// writes are always accepted, are meant to be made while the block is idle,
// and restart the current message with the new key and mode; a write to an
// index past the register list is ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module siphash_keyed_stream_hash import siph_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   siph_req_if.sink   req,
   siph_rsp_if.source rsp,
   siph_csr_if.sink   csr
);

   logic [WordWidth-1:0] key_low_ff,  key_low_in;
   logic [WordWidth-1:0] key_high_ff, key_high_in;
   logic                 wide_ff,     wide_in;
   lanes_type            lanes_ff,    lanes_in;
   logic [PartWidth-1:0] part_ff,     part_in;
   logic [LenWidth-1:0]  len_ff,      len_in;

   logic                  req_xfer;
   logic                  csr_xfer;
   logic                  csr_hit;
   logic [CountWidth-1:0] cnt;
   logic [WordWidth-1:0]  data_m;
   logic [2:0]            fill;
   logic [WordWidth-1:0]  acc;
   logic [WordWidth-1:0]  spill;
   logic                  full;
   lanes_type             lanes_abs;
   logic [PartWidth-1:0]  part_abs;
   logic [LenWidth-1:0]   len_abs;

   logic          fin_valid;
   logic          fin_ready;
   final_job_type fin_job;

   assign req_xfer  = req.valid && req.ready;
   assign csr_xfer  = csr.valid && csr.ready;
   assign csr.ready = 1'b1;
   assign req.ready = fin_ready;

   // clamp the count and drop bytes beyond it
   always_comb begin
      cnt = (req.byte_count > FullCount) ? FullCount : req.byte_count;
      for (int i = 0; i < BytesPerWord; i++) begin
         data_m[8*i +: 8] = (CountWidth'(i) < cnt) ? req.data_bytes[8*i +: 8] : 8'h00;
      end
   end

   // append to the partial block and compress a completed block
   always_comb begin
      fill      = len_ff[2:0];
      acc       = {8'h00, part_ff} | (data_m << {fill, 3'b000});
      spill     = (fill != 3'd0) ? (data_m >> (7'd64 - {1'b0, fill, 3'b000})) : '0;
      full      = ({1'b0, fill} + cnt) >= FullCount;
      lanes_abs = full ? compress(lanes_ff, acc) : lanes_ff;
      part_abs  = full ? spill[PartWidth-1:0] : acc[PartWidth-1:0];
      len_abs   = len_ff + LenWidth'(cnt);
   end

   // hand the last item to the finalization pipe
   assign fin_valid     = req_xfer && req.last;
   assign fin_job.lanes = lanes_abs;
   assign fin_job.m     = {len_abs, part_abs};
   assign fin_job.wide  = wide_ff;

   // register writes and message state update
   always_comb begin
      key_low_in  = key_low_ff;
      key_high_in = key_high_ff;
      wide_in     = wide_ff;
      csr_hit     = 1'b0;
      if (csr_xfer) begin
         unique case (csr.index)
            CsrKeyLow: begin
               key_low_in = csr.data;
               csr_hit    = 1'b1;
            end
            CsrKeyHigh: begin
               key_high_in = csr.data;
               csr_hit     = 1'b1;
            end
            CsrWideDigest: begin
               wide_in = csr.data[0];
               csr_hit = 1'b1;
            end
            default: begin
               csr_hit = 1'b0;
            end
         endcase
      end

      lanes_in = lanes_ff;
      part_in  = part_ff;
      len_in   = len_ff;
      if (csr_hit || (req_xfer && req.last)) begin
         lanes_in = start_lanes(key_low_in, key_high_in, wide_in);
         part_in  = '0;
         len_in   = '0;
      end else if (req_xfer) begin
         lanes_in = lanes_abs;
         part_in  = part_abs;
         len_in   = len_abs;
      end
   end

   // key, mode and message state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
         wide_ff     <= 1'b0;
         lanes_ff    <= start_lanes('0, '0, 1'b0);
         part_ff     <= '0;
         len_ff      <= '0;
      end else begin
         key_low_ff  <= key_low_in;
         key_high_ff <= key_high_in;
         wide_ff     <= wide_in;
         lanes_ff    <= lanes_in;
         part_ff     <= part_in;
         len_ff      <= len_in;
      end
   end

   siph_final u_final (
      .clock     (clock),
      .reset     (reset),
      .fin_valid (fin_valid),
      .fin_ready (fin_ready),
      .fin_job   (fin_job),
      .rsp       (rsp)
   );

   // a finished message leaves no bytes and no length behind
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req.last |=> (len_ff == '0) && (part_ff == '0))
      else $error("message state not cleared after last transfer");

   // a plain transfer advances the length by the clamped count
   a_len_advance: assert property (@(posedge clock) disable iff (reset)
      req_xfer && !req.last && !csr.valid |=>
         len_ff == $past(len_ff) + LenWidth'($past(cnt)))
      else $error("length did not advance by the byte count");

   // partial block holds no bytes above the fill level
   a_part_clean: assert property (@(posedge clock) disable iff (reset)
      (({8'h00, part_ff} >> {len_ff[2:0], 3'b000}) == '0))
      else $error("stray bytes above the partial block fill");

endmodule

`default_nettype wire
